### rtl/core/mrt_pkg.sv
// ----------------------------------------------------------------------------
// mrt_pkg
// Shared types and constants of the markup run tokenizer: byte classes, the
// layout of a queue entry and the token record.
// ----------------------------------------------------------------------------
package mrt_pkg;

  localparam int LENGTH_BITS_DEF = 16;
  localparam int OFFSET_BITS_DEF = 32;

  // Fixed widths of the token fields on the ports.
  localparam int CHAR_W   = 8;
  localparam int OFFSET_W = 32;
  localparam int LENGTH_W = 16;
  localparam int VALUE_W  = 32;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    KIND_MARK    = 3'd0,
    KIND_NEWLINE = 3'd1,
    KIND_BLANK   = 3'd2,
    KIND_DIGIT   = 3'd3,
    KIND_OTHER   = 3'd4
  } kind_t;

  localparam int KIND_W = $bits(kind_t);

  // Queue entry layout: {position, kind, last, byte}.
  localparam int Q_DATA_LSB = 0;
  localparam int Q_LAST_BIT = CHAR_W;
  localparam int Q_KIND_LSB = CHAR_W + 1;
  localparam int Q_POS_LSB  = CHAR_W + 1 + KIND_W;

  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [CHAR_W-1:0]          first_char;
    logic [OFFSET_W-1:0]        start_offset;
    logic [LENGTH_W-1:0]        token_length;
    logic signed [VALUE_W-1:0]  digit_value;
    logic                       is_space;
    logic                       is_newline;
    logic                       stream_end;
  } tok_t;

endpackage

### rtl/core/mrt_byte_if.sv
// ----------------------------------------------------------------------------
// mrt_byte_if
// Byte channel: one text byte and its end-of-stream mark per word.
// ----------------------------------------------------------------------------
interface mrt_byte_if;
  import mrt_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);

endinterface

### rtl/core/mrt_token_if.sv
// ----------------------------------------------------------------------------
// mrt_token_if
// Token channel: one finished token per word.
// ----------------------------------------------------------------------------
interface mrt_token_if;
  import mrt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CHAR_W-1:0]         first_char;
  logic [OFFSET_W-1:0]       start_offset;
  logic [LENGTH_W-1:0]       token_length;
  logic signed [VALUE_W-1:0] digit_value;
  logic                      is_space;
  logic                      is_newline;
  logic                      stream_end;

  modport source (
    output valid, output first_char, output start_offset, output token_length,
    output digit_value, output is_space, output is_newline, output stream_end,
    input ready
  );
  modport sink (
    input valid, input first_char, input start_offset, input token_length,
    input digit_value, input is_space, input is_newline, input stream_end,
    output ready
  );

endinterface

### rtl/core/mrt_front.sv
// ----------------------------------------------------------------------------
// mrt_front
// Accepts text bytes, classifies each one and tags it with its stream
// position before it enters the queue.
// ----------------------------------------------------------------------------
module mrt_front #(
  parameter int OFFSET_BITS = mrt_pkg::OFFSET_BITS_DEF,
  parameter int Q_W         = mrt_pkg::Q_POS_LSB + OFFSET_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [mrt_pkg::CHAR_W-1:0] data_byte,
  input  logic                      last_byte,
  output logic                      wr_valid,
  input  logic                      wr_ready,
  output logic [Q_W-1:0]            wr_data
);
  import mrt_pkg::*;

  logic [OFFSET_BITS-1:0] position;
  kind_t                  kind;

  always_comb begin
    case (data_byte) inside
      8'h2A, 8'h23, 8'h60, 8'h2E, 8'h5F, 8'h2D, 8'h5B, 8'h5D,
      8'h28, 8'h29, 8'h7B, 8'h7D, 8'h3C, 8'h3E:
        kind = KIND_MARK;
      CH_LF, CH_CR:
        kind = KIND_NEWLINE;
      CH_SPACE, CH_TAB, CH_VT, CH_FF:
        kind = KIND_BLANK;
      [CH_ZERO:CH_NINE]:
        kind = KIND_DIGIT;
      default:
        kind = KIND_OTHER;
    endcase
  end

  assign in_ready = wr_ready;
  assign wr_valid = in_valid;
  assign wr_data  = {position, kind, last_byte, data_byte};

  // Positions restart at zero after the last byte of a stream.
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (in_valid && wr_ready) begin
      position <= last_byte ? '0 : position + 1'b1;
    end
  end

endmodule

### rtl/core/mrt_fifo.sv
// ----------------------------------------------------------------------------
// mrt_fifo
// Small register queue that decouples the classifier from the token builder.
// ----------------------------------------------------------------------------
module mrt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mrt_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

### rtl/core/mrt_back.sv
// ----------------------------------------------------------------------------
// mrt_back
// Token builder: holds the open run, decides per byte whether it continues,
// and writes up to two finished tokens per byte into a small output buffer.
// ----------------------------------------------------------------------------
module mrt_back #(
  parameter int LENGTH_BITS = mrt_pkg::LENGTH_BITS_DEF,
  parameter int OFFSET_BITS = mrt_pkg::OFFSET_BITS_DEF,
  parameter int Q_W         = mrt_pkg::Q_POS_LSB + OFFSET_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  logic [Q_W-1:0] q_data,
  output logic          tok_valid,
  input  logic          tok_ready,
  output mrt_pkg::tok_t tok_data
);
  import mrt_pkg::*;

  localparam int RUN_W   = VALUE_W - 1;
  localparam int OUT_DEP = 4;
  localparam int OPTR_W  = $clog2(OUT_DEP);
  localparam int OCNT_W  = $clog2(OUT_DEP + 1);
  localparam logic [RUN_W-1:0] RUN_MAX = '1;

  // Open run.
  logic                   token_open;
  kind_t                  token_kind;
  logic [CHAR_W-1:0]      run_char;
  logic [OFFSET_BITS-1:0] token_start;
  logic [LENGTH_BITS-1:0] run_length;
  logic [RUN_W-1:0]       run_value;

  // Output buffer.
  tok_t              obuf [OUT_DEP];
  logic [OPTR_W-1:0] o_wr_ptr;
  logic [OPTR_W-1:0] o_rd_ptr;
  logic [OCNT_W-1:0] o_count;

  logic [CHAR_W-1:0]      c;
  logic                   c_last;
  kind_t                  c_kind;
  logic [OFFSET_BITS-1:0] c_pos;
  logic                   c_lf;
  logic                   fire;
  logic                   pop;
  logic                   more;
  logic                   cont;
  logic                   start_new;
  logic [LENGTH_BITS-1:0] len_inc;
  logic [RUN_W+3:0]       val_wide;
  logic [RUN_W-1:0]       val_inc;
  logic                   e0;
  logic                   e1;
  tok_t                   t0;
  tok_t                   t1;
  logic [RUN_W-1:0]       new_value;
  logic [OPTR_W-1:0]      e1_ptr;

  function automatic tok_t make_tok(
    input logic [CHAR_W-1:0]      ch,
    input logic [OFFSET_BITS-1:0] st,
    input logic [LENGTH_BITS-1:0] len,
    input logic [RUN_W-1:0]       val,
    input kind_t                  k,
    input logic                   fin
  );
    tok_t t;
    t.first_char   = ch;
    t.start_offset = OFFSET_W'(st);
    t.token_length = LENGTH_W'(len);
    t.digit_value  = (k == KIND_DIGIT) ? signed'({1'b0, val}) : '1;
    t.is_space     = (k == KIND_NEWLINE) || (k == KIND_BLANK);
    t.is_newline   = (k == KIND_NEWLINE);
    t.stream_end   = fin;
    return t;
  endfunction

  always_comb begin
    c      = q_data[Q_DATA_LSB +: CHAR_W];
    c_last = q_data[Q_LAST_BIT];
    c_kind = kind_t'(q_data[Q_KIND_LSB +: KIND_W]);
    c_pos  = q_data[Q_POS_LSB +: OFFSET_BITS];
    c_lf   = (c == CH_LF);

    case (token_kind)
      KIND_MARK:    more = (c == run_char);
      KIND_NEWLINE: more = c_lf;
      KIND_BLANK:   more = (c_kind == KIND_BLANK);
      KIND_DIGIT:   more = (c_kind == KIND_DIGIT);
      default:      more = (c_kind == KIND_OTHER) || (c_kind == KIND_DIGIT);
    endcase

    cont      = token_open && more;
    start_new = !cont;

    len_inc  = (run_length != '1) ? run_length + 1'b1 : run_length;
    // value * 10 + digit, saturating at the largest positive 32-bit value
    val_wide = {run_value, 3'b000} + {2'b00, run_value, 1'b0} + (RUN_W + 4)'(c[3:0]);
    val_inc  = (val_wide[RUN_W+3:RUN_W] != '0) ? RUN_MAX : val_wide[RUN_W-1:0];

    // The open token closes on a byte that ends it, on the LF of a CR LF
    // pair, or together with the last byte of the stream.
    e0 = token_open && (!more || token_kind == KIND_NEWLINE || c_last);
    t0 = make_tok(run_char, token_start,
                  more ? len_inc : run_length,
                  more ? val_inc : run_value,
                  token_kind, more && c_last);

    new_value = (c_kind == KIND_DIGIT) ? RUN_W'(c[3:0]) : '0;
    e1 = start_new && (c_lf || c_last);
    t1 = make_tok(c, c_pos, LENGTH_BITS'(1), new_value, c_kind, c_last);

    e1_ptr = o_wr_ptr + OPTR_W'(e0);
  end

  assign fire      = q_valid && (o_count <= OCNT_W'(OUT_DEP - 2));
  assign q_ready   = fire;
  assign tok_valid = (o_count != '0);
  assign tok_data  = obuf[o_rd_ptr];
  assign pop       = tok_valid && tok_ready;

  always_ff @(posedge clk) begin
    if (fire) begin
      if (e0) begin
        obuf[o_wr_ptr] <= t0;
      end
      if (e1) begin
        obuf[e1_ptr] <= t1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (cont) begin
        run_length <= len_inc;
        run_value  <= val_inc;
      end else begin
        run_char    <= c;
        token_start <= c_pos;
        run_length  <= LENGTH_BITS'(1);
        run_value   <= new_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_open <= 1'b0;
      token_kind <= KIND_MARK;
      o_wr_ptr   <= '0;
      o_rd_ptr   <= '0;
      o_count    <= '0;
    end else begin
      if (fire) begin
        if (cont) begin
          token_open <= !(token_kind == KIND_NEWLINE || c_last);
        end else begin
          token_kind <= c_kind;
          token_open <= !(c_lf || c_last);
        end
        o_wr_ptr <= o_wr_ptr + OPTR_W'(e0) + OPTR_W'(e1);
      end
      if (pop) begin
        o_rd_ptr <= o_rd_ptr + 1'b1;
      end
      o_count <= o_count + (fire ? OCNT_W'(e0) + OCNT_W'(e1) : '0) - OCNT_W'(pop);
    end
  end

endmodule

### rtl/core/markup_run_tokenizer.sv
// ----------------------------------------------------------------------------
// markup_run_tokenizer
// Groups a text byte stream into markup, newline, blank, digit and word
// tokens, each with first byte, offset, length, value and flags.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the output buffer has room; a byte that
// closes one token and completes another puts two words on the output, which
// drain one per cycle while the sink is ready. The byte that closes a token
// is registered in the byte queue, and the token then in the output buffer.
// Reset (synchronous, rst high) empties both queues, closes any open token
// and sets the stream position to zero.
module markup_run_tokenizer #(
  parameter int LENGTH_BITS = mrt_pkg::LENGTH_BITS_DEF,
  parameter int OFFSET_BITS = mrt_pkg::OFFSET_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  mrt_byte_if.sink   bytes,
  mrt_token_if.source tokens
);
  import mrt_pkg::*;

  localparam int Q_W = Q_POS_LSB + OFFSET_BITS;

  logic           f_valid;
  logic           f_ready;
  logic [Q_W-1:0] f_data;
  logic           q_valid;
  logic           q_ready;
  logic [Q_W-1:0] q_data;
  tok_t           tok;

  mrt_front #(
    .OFFSET_BITS (OFFSET_BITS),
    .Q_W         (Q_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (bytes.valid),
    .in_ready  (bytes.ready),
    .data_byte (bytes.data_byte),
    .last_byte (bytes.last_byte),
    .wr_valid  (f_valid),
    .wr_ready  (f_ready),
    .wr_data   (f_data)
  );

  mrt_fifo #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  mrt_back #(
    .LENGTH_BITS (LENGTH_BITS),
    .OFFSET_BITS (OFFSET_BITS),
    .Q_W         (Q_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .tok_valid (tokens.valid),
    .tok_ready (tokens.ready),
    .tok_data  (tok)
  );

  assign tokens.first_char   = tok.first_char;
  assign tokens.start_offset = tok.start_offset;
  assign tokens.token_length = tok.token_length;
  assign tokens.digit_value  = tok.digit_value;
  assign tokens.is_space     = tok.is_space;
  assign tokens.is_newline   = tok.is_newline;
  assign tokens.stream_end   = tok.stream_end;

endmodule
